@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the clipping block.
// Depends on nothing; the user supplies clock and reset names or uses the defaults.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock, disabled while reset is high.
`define LCU_ASSERT_ON(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("line clip check failed");

// Same, on the usual clock and reset names.
`define LCU_ASSERT(label, prop) `LCU_ASSERT_ON(label, clock, reset, prop)

`endif

@@ rtl/lcu_pkg.sv @@
// Package of the unit-cube line clipper: default widths and a packing helper.
// Used by line_clip_unit_cube and by its checker.
`default_nettype none

package lcu_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int REQ_USER_W      = 2;
   localparam int RSP_USER_W      = 3;

   function automatic int pad_bytes(input int w);
      return ((w + 7) / 8) * 8;
   endfunction

endpackage

`default_nettype wire

@@ rtl/line_clip_unit_cube.sv @@
// Top level of the 3D Liang-Barsky clipper against the cube [-1,1].
// Depends on lcu_pkg.
`default_nettype none

// One segment enters per cycle unless the result side stalls. The six crossing divisions run
// as restoring dividers that resolve one quotient bit per pipeline stage, after a first stage
// that checks for saturation; the window narrowing, the six multiplies and the final rounding
// each take a stage of their own. A stall on the result side holds the whole pipeline without
// loss.
module line_clip_unit_cube
   import lcu_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // from_x, from_y, from_z, to_x, to_y, to_z, then zero fill.
   input  wire logic [pad_bytes(6*COORD_WIDTH)-1:0]    req_tdata,
   // axis_tag.
   input  wire logic [REQ_USER_W-1:0]                  req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // clip_from_x/y/z, clip_to_x/y/z, entry_amount, exit_amount, then zero fill.
   output logic [pad_bytes(6*(FRAC_BITS+2)+2*(FRAC_BITS+1))-1:0] rsp_tdata,
   // accepted, axis_out.
   output logic [RSP_USER_W-1:0]                       rsp_tuser
);

   localparam int CW   = COORD_WIDTH;
   localparam int FB   = FRAC_BITS;
   localparam int DW   = CW + 1;
   localparam int QB   = FB + 2;
   localparam int MX   = ((FB > CW - 1) ? FB : CW - 1) + 1;
   localparam int NW   = MX + 2;
   localparam int RA   = NW + FB;
   localparam int RB   = DW + QB;
   localparam int RW   = ((RA > RB) ? RA : RB) + 1;
   localparam int TW   = FB + 3;
   localparam int PW   = DW + FB + 2;
   localparam int VW   = PW + 1;
   localparam int OCW  = FB + 2;
   localparam int AW   = FB + 1;
   localparam int ODW  = pad_bytes(6*OCW + 2*AW);
   localparam longint ONE_V = longint'(1) << FB;

   typedef struct packed {
      logic [2:0][CW-1:0] s;
      logic [2:0][DW-1:0] d;
      logic [2:0]         dz;
      logic [2:0]         outside;
      logic [5:0]         neg;
      logic [5:0]         nz;
      logic [1:0]         tag;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] r;
      logic [DW-1:0] den;
      logic [QB-1:0] q;
      logic          sat;
   } lane_type;

   logic advance;

   logic               a_vld_ff;
   logic [2:0][CW-1:0] a_from_ff, a_to_ff;
   logic [1:0]         a_tag_ff;

   side_type b_side_in;
   lane_type b_lane_in [0:5];

   logic [QB+1:0] dv_vld_ff;
   side_type      dv_side_ff [0:QB+1];
   lane_type      dv_lane_ff [0:QB+1][0:5];
   lane_type      dv_lane_in [1:QB+1][0:5];

   logic                    c_vld_ff;
   side_type                c_side_ff;
   logic signed [TW-1:0]    c_cross_ff [0:5];
   logic signed [TW-1:0]    c_cross_in [0:5];

   logic                    d_vld_ff, d_ok_ff, d_ok_in;
   side_type                d_side_ff;
   logic signed [TW-1:0]    d_tmin_ff, d_tmax_ff, d_tmin_in, d_tmax_in;

   logic                    e_vld_ff, e_ok_ff;
   logic [2:0][CW-1:0]      e_s_ff;
   logic [1:0]              e_tag_ff;
   logic [AW-1:0]           e_tmin_ff, e_tmax_ff;
   logic signed [PW-1:0]    e_prod_ff [0:5];
   logic signed [PW-1:0]    e_prod_in [0:5];

   logic                    o_vld_ff;
   logic [ODW-1:0]          o_data_ff, o_data_in;
   logic [RSP_USER_W-1:0]   o_user_ff, o_user_in;

   assign advance    = !o_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         dv_vld_ff <= '0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
         e_vld_ff  <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else if (advance) begin
         a_vld_ff  <= req_tvalid;
         dv_vld_ff <= {dv_vld_ff[QB:0], a_vld_ff};
         c_vld_ff  <= dv_vld_ff[QB+1];
         d_vld_ff  <= c_vld_ff;
         e_vld_ff  <= d_vld_ff;
         o_vld_ff  <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            a_from_ff[a] <= req_tdata[a*CW +: CW];
            a_to_ff[a]   <= req_tdata[(3+a)*CW +: CW];
         end
         a_tag_ff      <= req_tuser;
         dv_side_ff[0] <= b_side_in;
         for (int l = 0; l < 6; l++) begin
            dv_lane_ff[0][l] <= b_lane_in[l];
         end
         for (int i = 1; i <= QB + 1; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
            for (int l = 0; l < 6; l++) begin
               dv_lane_ff[i][l] <= dv_lane_in[i][l];
            end
         end
         c_side_ff <= dv_side_ff[QB+1];
         for (int l = 0; l < 6; l++) begin
            c_cross_ff[l] <= c_cross_in[l];
            e_prod_ff[l]  <= e_prod_in[l];
         end
         d_side_ff <= c_side_ff;
         d_tmin_ff <= d_tmin_in;
         d_tmax_ff <= d_tmax_in;
         d_ok_ff   <= d_ok_in;
         e_s_ff    <= d_side_ff.s;
         e_tag_ff  <= d_side_ff.tag;
         e_ok_ff   <= d_ok_ff;
         e_tmin_ff <= d_tmin_ff[AW-1:0];
         e_tmax_ff <= d_tmax_ff[AW-1:0];
         o_data_ff <= o_data_in;
         o_user_ff <= o_user_in;
      end
   end

   always_comb begin : prep
      logic signed [CW-1:0] s_v, t_v;
      logic signed [DW-1:0] d_v;
      logic signed [NW-1:0] s_n, one_n, num_v;
      logic [NW-1:0]        abs_v;
      logic [DW-1:0]        den_v;
      b_side_in     = '0;
      b_side_in.tag = a_tag_ff;
      one_n         = NW'(ONE_V);
      for (int a = 0; a < 3; a++) begin
         s_v   = $signed(a_from_ff[a]);
         t_v   = $signed(a_to_ff[a]);
         d_v   = DW'(t_v) - DW'(s_v);
         s_n   = NW'(s_v);
         den_v = d_v[DW-1] ? -d_v : d_v;
         b_side_in.s[a]       = a_from_ff[a];
         b_side_in.d[a]       = d_v;
         b_side_in.dz[a]      = (d_v == '0);
         b_side_in.outside[a] = (s_n < -one_n) || (s_n > one_n);
         for (int b = 0; b < 2; b++) begin
            num_v = (b == 1) ? (one_n - s_n) : (-one_n - s_n);
            abs_v = num_v[NW-1] ? -num_v : num_v;
            b_side_in.neg[2*a+b] = num_v[NW-1] ^ d_v[DW-1];
            b_side_in.nz[2*a+b]  = (num_v == '0);
            b_lane_in[2*a+b].r   = RW'(abs_v) << FB;
            b_lane_in[2*a+b].den = den_v;
            b_lane_in[2*a+b].q   = '0;
            b_lane_in[2*a+b].sat = 1'b0;
         end
      end
   end

   always_comb begin : div_step
      logic [RW-1:0] part;
      for (int i = 0; i <= QB; i++) begin
         for (int l = 0; l < 6; l++) begin
            dv_lane_in[i+1][l] = dv_lane_ff[i][l];
            part = RW'(dv_lane_ff[i][l].den) << (QB - i);
            if (i == 0) begin
               dv_lane_in[i+1][l].sat = (dv_lane_ff[i][l].r >= part);
            end else if (dv_lane_ff[i][l].r >= part) begin
               dv_lane_in[i+1][l].r          = dv_lane_ff[i][l].r - part;
               dv_lane_in[i+1][l].q[QB - i]  = 1'b1;
            end
         end
      end
   end

   always_comb begin : cross_fix
      lane_type ln;
      for (int l = 0; l < 6; l++) begin
         ln = dv_lane_ff[QB+1][l];
         if (dv_side_ff[QB+1].neg[l]) begin
            c_cross_in[l] = dv_side_ff[QB+1].nz[l] ? '0 : -TW'(1);
         end else if (ln.sat || (TW'(ln.q) > TW'(ONE_V + 1))) begin
            c_cross_in[l] = TW'(ONE_V + 1);
         end else begin
            c_cross_in[l] = TW'(ln.q);
         end
      end
   end

   always_comb begin : narrow
      logic signed [TW-1:0] lo, hi;
      logic                 rej;
      d_tmin_in = '0;
      d_tmax_in = TW'(ONE_V);
      rej       = 1'b0;
      for (int a = 0; a < 3; a++) begin
         lo = (c_cross_ff[2*a] < c_cross_ff[2*a+1]) ? c_cross_ff[2*a] : c_cross_ff[2*a+1];
         hi = (c_cross_ff[2*a] < c_cross_ff[2*a+1]) ? c_cross_ff[2*a+1] : c_cross_ff[2*a];
         if (c_side_ff.dz[a]) begin
            rej = rej | c_side_ff.outside[a];
         end else begin
            if (lo > d_tmin_in) begin
               d_tmin_in = lo;
            end
            if (hi < d_tmax_in) begin
               d_tmax_in = hi;
            end
         end
      end
      d_ok_in = !rej && (d_tmin_in <= d_tmax_in);
   end

   always_comb begin : scale
      logic signed [DW-1:0] d_v;
      logic signed [AW:0]   amin, amax;
      amin = $signed({1'b0, d_tmin_ff[AW-1:0]});
      amax = $signed({1'b0, d_tmax_ff[AW-1:0]});
      for (int a = 0; a < 3; a++) begin
         d_v            = $signed(d_side_ff.d[a]);
         e_prod_in[a]   = d_v * amin;
         e_prod_in[3+a] = d_v * amax;
      end
   end

   always_comb begin : place
      logic signed [PW-1:0] acc;
      logic signed [VW-1:0] v, one_v;
      one_v     = VW'(ONE_V);
      o_data_in = '0;
      for (int l = 0; l < 6; l++) begin
         acc = e_prod_ff[l] + PW'(ONE_V >> 1);
         v   = VW'($signed(e_s_ff[l % 3])) + VW'(acc >>> FB);
         if (v > one_v) begin
            v = one_v;
         end else if (v < -one_v) begin
            v = -one_v;
         end
         if (e_ok_ff) begin
            o_data_in[l*OCW +: OCW] = v[OCW-1:0];
         end
      end
      if (e_ok_ff) begin
         o_data_in[6*OCW +: AW]      = e_tmin_ff;
         o_data_in[6*OCW + AW +: AW] = e_tmax_ff;
      end
      o_user_in = {e_tag_ff, e_ok_ff};
   end

endmodule

`default_nettype wire

@@ rtl/lcu_check.sv @@
// Port-level checker for line_clip_unit_cube, attached by the bind at the end.
// Depends on lcu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lcu_check
   import lcu_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_tready,
   input wire logic                                   rsp_tvalid,
   input wire logic                                   rsp_tready,
   input wire logic [pad_bytes(6*(FRAC_BITS+2)+2*(FRAC_BITS+1))-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0]                  rsp_tuser
);

   localparam int OCW = FRAC_BITS + 2;
   localparam int AW  = FRAC_BITS + 1;
   localparam logic [AW-1:0] ONE_A = AW'(longint'(1) << FRAC_BITS);

   logic [AW-1:0] entry_w, exit_w;

   assign entry_w = rsp_tdata[6*OCW +: AW];
   assign exit_w  = rsp_tdata[6*OCW + AW +: AW];

   `LCU_ASSERT(a_stall_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `LCU_ASSERT(a_reject_zero, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
   `LCU_ASSERT(a_window, rsp_tvalid && rsp_tuser[0] |-> entry_w <= exit_w && exit_w <= ONE_A)
   `LCU_ASSERT(a_ready_free, !rsp_tvalid |-> req_tready)

endmodule

bind line_clip_unit_cube lcu_check #(
   .COORD_WIDTH(COORD_WIDTH),
   .FRAC_BITS  (FRAC_BITS)
) u_lcu_check (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
